/* sv/hsv_to_rgb_converter_defines.svh */
// Assertion macros shared by the HSV to RGB converter checkers
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define HSV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check that a condition is followed by a consequence in the next cycle
`define HSV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hsv_pkg.sv */
// Types, constants and helper functions of the HSV to RGB converter
package hsv_pkg;

    // Color arithmetic constants
    localparam int unsigned HUE_MOD     = 360;
    localparam int unsigned SECTOR_DEG  = 60;
    localparam int unsigned FULL        = 255;
    localparam int unsigned HALF_FULL   = 128;
    localparam int unsigned HALF_SECTOR = 30;

    // hue / 360 as (hue * HUE_RECIP) >> HUE_RECIP_SHIFT, exact for 16-bit hues
    localparam int unsigned HUE_RECIP_SHIFT = 24;
    localparam int unsigned HUE_RECIP = ((1 << HUE_RECIP_SHIFT) + HUE_MOD - 1) / HUE_MOD;

    // (x * 255 + 30) / 60 reduces to (x * 17 + 2) / 4
    localparam int unsigned FRAC_DIV   = SECTOR_DEG / 4;
    localparam int unsigned FRAC_MUL   = FULL / FRAC_DIV;
    localparam int unsigned FRAC_ROUND = HALF_SECTOR / FRAC_DIV;

    // x / 255 as (x * DIV255_MUL) >> DIV255_SHIFT, exact for x below 2**16
    localparam int unsigned DIV255_SHIFT = 23;
    localparam int unsigned DIV255_MUL   = ((1 << DIV255_SHIFT) + FULL - 1) / FULL;

    // Pipeline shape
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned FRONT_STAGES = 3;
    localparam int unsigned BACK_STAGES  = 4;

    // Hue sectors, 60 degrees each
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic [15:0] hue_deg;
        logic [7:0]  sat_level;
        logic [7:0]  val_level;
    } t_hsv;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Classified color handed from the front end to the back end
    typedef struct packed {
        t_sector    sector;
        logic [7:0] frac;
        logic [7:0] sat_level;
        logic [7:0] val_level;
    } t_work;

    // Divide a value below 2**16 by 255, truncating
    function automatic logic [7:0] div255(input logic [16:0] x);
        logic [32:0] prod;
        prod = 33'(x) * 33'(DIV255_MUL);
        return prod[DIV255_SHIFT +: 8];
    endfunction

endpackage

/* sv/hsv_if.sv */
// Stream interfaces carrying HSV input words and RGB result words
interface hsv_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue_deg;
    logic [7:0]  sat_level;
    logic [7:0]  val_level;

    modport source (output valid, output hue_deg, output sat_level, output val_level,
                    input ready);
    modport sink (input valid, input hue_deg, input sat_level, input val_level,
                  output ready);
endinterface

interface rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* sv/hsv_front.sv */
// Front end: reduces the hue modulo 360 and finds sector and fraction
module hsv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  hsv_pkg::t_hsv  i_hsv,
    output logic           o_ready,
    output logic           o_valid,
    output hsv_pkg::t_work o_work,
    input  logic           i_ready
);

    typedef struct packed {
        logic [15:0] hue_deg;
        logic [31:0] quot_prod;
        logic [7:0]  sat_level;
        logic [7:0]  val_level;
    } t_fstage1;

    typedef struct packed {
        logic [8:0] angle;
        logic [7:0] sat_level;
        logic [7:0] val_level;
    } t_fstage2;

    logic           r_v1, r_v2, r_v3;
    logic           n_v1, n_v2, n_v3;
    t_fstage1       r_s1, n_s1;
    t_fstage2       r_s2, n_s2;
    hsv_pkg::t_work r_s3, n_s3;
    logic           adv;

    // Advance the whole front end when the last stage can leave
    assign adv     = !r_v3 || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v3;
    assign o_work  = r_s3;

    // Stage 1: multiply by the reciprocal of 360
    always_comb begin
        n_v1             = i_valid;
        n_s1.hue_deg     = i_hsv.hue_deg;
        n_s1.quot_prod   = 32'(i_hsv.hue_deg) * 32'(hsv_pkg::HUE_RECIP);
        n_s1.sat_level   = i_hsv.sat_level;
        n_s1.val_level   = i_hsv.val_level;
    end

    // Stage 2: subtract quotient times 360 to get the angle
    always_comb begin
        logic [7:0]  quot;
        logic [16:0] diff;
        quot           = r_s1.quot_prod[hsv_pkg::HUE_RECIP_SHIFT +: 8];
        diff           = 17'(r_s1.hue_deg) - 17'(quot) * 17'(hsv_pkg::HUE_MOD);
        n_v2           = r_v1;
        n_s2.angle     = diff[8:0];
        n_s2.sat_level = r_s1.sat_level;
        n_s2.val_level = r_s1.val_level;
    end

    // Stage 3: pick the sector and round the position into a fraction
    always_comb begin
        logic [8:0] base;
        logic [5:0] offs;
        logic [9:0] frac_sum;
        if (r_s2.angle < 9'(hsv_pkg::SECTOR_DEG)) begin
            n_s3.sector = hsv_pkg::SEC_RED_YEL;
            base        = 9'd0;
        end else if (r_s2.angle < 9'(2 * hsv_pkg::SECTOR_DEG)) begin
            n_s3.sector = hsv_pkg::SEC_YEL_GRN;
            base        = 9'(hsv_pkg::SECTOR_DEG);
        end else if (r_s2.angle < 9'(3 * hsv_pkg::SECTOR_DEG)) begin
            n_s3.sector = hsv_pkg::SEC_GRN_CYN;
            base        = 9'(2 * hsv_pkg::SECTOR_DEG);
        end else if (r_s2.angle < 9'(4 * hsv_pkg::SECTOR_DEG)) begin
            n_s3.sector = hsv_pkg::SEC_CYN_BLU;
            base        = 9'(3 * hsv_pkg::SECTOR_DEG);
        end else if (r_s2.angle < 9'(5 * hsv_pkg::SECTOR_DEG)) begin
            n_s3.sector = hsv_pkg::SEC_BLU_MAG;
            base        = 9'(4 * hsv_pkg::SECTOR_DEG);
        end else begin
            n_s3.sector = hsv_pkg::SEC_MAG_RED;
            base        = 9'(5 * hsv_pkg::SECTOR_DEG);
        end
        offs           = 6'(r_s2.angle - base);
        frac_sum       = 10'(offs) * 10'(hsv_pkg::FRAC_MUL) + 10'(hsv_pkg::FRAC_ROUND);
        n_s3.frac      = frac_sum[9:2];
        n_s3.sat_level = r_s2.sat_level;
        n_s3.val_level = r_s2.val_level;
        n_v3           = r_v2;
    end

    // Clear valid bits under reset, move every stage together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

endmodule

/* sv/hsv_queue.sv */
// Short queue between front end and back end
module hsv_queue #(
    parameter int unsigned DEPTH = hsv_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  hsv_pkg::t_work i_work,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output hsv_pkg::t_work o_work,
    input  logic           i_pop_ready
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    hsv_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_work       = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

/* sv/hsv_back.sv */
// Back end: forms p, q and t and orders them into red, green and blue
module hsv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  hsv_pkg::t_work i_work,
    output logic           o_ready,
    output logic           o_valid,
    output hsv_pkg::t_rgb  o_rgb,
    input  logic           i_ready
);

    typedef struct packed {
        hsv_pkg::t_sector sector;
        logic             gray;
        logic [7:0]       val_level;
        logic [15:0]      prod_sf;
        logic [15:0]      prod_sfc;
        logic [15:0]      prod_vs;
    } t_bstage1;

    typedef struct packed {
        hsv_pkg::t_sector sector;
        logic             gray;
        logic [7:0]       val_level;
        logic [7:0]       q_term;
        logic [7:0]       t_term;
        logic [7:0]       p_level;
    } t_bstage2;

    typedef struct packed {
        hsv_pkg::t_sector sector;
        logic             gray;
        logic [7:0]       val_level;
        logic [7:0]       p_level;
        logic [15:0]      prod_q;
        logic [15:0]      prod_t;
    } t_bstage3;

    logic          r_v1, r_v2, r_v3, r_vo;
    t_bstage1      r_s1, n_s1;
    t_bstage2      r_s2, n_s2;
    t_bstage3      r_s3, n_s3;
    hsv_pkg::t_rgb r_rgb, n_rgb;
    logic          adv;

    // Advance when the output register is free or being taken
    assign adv     = !r_vo || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vo;
    assign o_rgb   = r_rgb;

    // Stage 1: saturation products
    always_comb begin
        n_s1.sector    = i_work.sector;
        n_s1.gray      = (i_work.sat_level == 8'd0);
        n_s1.val_level = i_work.val_level;
        n_s1.prod_sf   = 16'(i_work.sat_level) * 16'(i_work.frac);
        n_s1.prod_sfc  = 16'(i_work.sat_level) * 16'(8'(hsv_pkg::FULL) - i_work.frac);
        n_s1.prod_vs   = 16'(i_work.val_level) * 16'(8'(hsv_pkg::FULL) - i_work.sat_level);
    end

    // Stage 2: scale by 1/255, q term rounded, t term truncated, p rounded
    always_comb begin
        n_s2.sector    = r_s1.sector;
        n_s2.gray      = r_s1.gray;
        n_s2.val_level = r_s1.val_level;
        n_s2.q_term    = hsv_pkg::div255(17'(r_s1.prod_sf) + 17'(hsv_pkg::HALF_FULL));
        n_s2.t_term    = hsv_pkg::div255(17'(r_s1.prod_sfc));
        n_s2.p_level   = hsv_pkg::div255(17'(r_s1.prod_vs) + 17'(hsv_pkg::HALF_FULL));
    end

    // Stage 3: value products for q and t
    always_comb begin
        n_s3.sector    = r_s2.sector;
        n_s3.gray      = r_s2.gray;
        n_s3.val_level = r_s2.val_level;
        n_s3.p_level   = r_s2.p_level;
        n_s3.prod_q    = 16'(r_s2.val_level) * 16'(8'(hsv_pkg::FULL) - r_s2.q_term);
        n_s3.prod_t    = 16'(r_s2.val_level) * 16'(8'(hsv_pkg::FULL) - r_s2.t_term);
    end

    // Stage 4: finish q and t, order the channels by sector
    always_comb begin
        logic [7:0] q_level;
        logic [7:0] t_level;
        logic [7:0] v_level;
        logic [7:0] p_level;
        q_level = hsv_pkg::div255(17'(r_s3.prod_q) + 17'(hsv_pkg::HALF_FULL));
        t_level = hsv_pkg::div255(17'(r_s3.prod_t));
        v_level = r_s3.val_level;
        p_level = r_s3.p_level;
        case (r_s3.sector)
            hsv_pkg::SEC_RED_YEL: n_rgb = '{v_level, t_level, p_level};
            hsv_pkg::SEC_YEL_GRN: n_rgb = '{q_level, v_level, p_level};
            hsv_pkg::SEC_GRN_CYN: n_rgb = '{p_level, v_level, t_level};
            hsv_pkg::SEC_CYN_BLU: n_rgb = '{p_level, q_level, v_level};
            hsv_pkg::SEC_BLU_MAG: n_rgb = '{t_level, p_level, v_level};
            default:              n_rgb = '{v_level, p_level, q_level};
        endcase
        if (r_s3.gray) begin
            n_rgb = '{v_level, v_level, v_level};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_rgb <= n_rgb;
        end
    end

endmodule

/* sv/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB converter
//
//  port    | dir | word                              | handshake
//  --------+-----+-----------------------------------+-------------
//  i_hsv   | in  | hue_deg 16b, sat_level, val_level | valid/ready
//  o_rgb   | out | red, green, blue (8b each)        | valid/ready
//
// Takes one word per cycle while o_rgb does not stall; each word passes
// through the front-end stages, the queue and the back-end stages.
// The two 8x8 multiply-and-scale steps of the back end set the stage count.
// Reset is synchronous, active low, and empties all stages and the queue.
// A stall on o_rgb holds the back end; the queue keeps the front end
// taking words until it is full.
module hsv_to_rgb_converter #(
    parameter int unsigned QUEUE_DEPTH = hsv_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsv_in_if.sink    i_hsv,
    rgb_out_if.source o_rgb
);

    hsv_pkg::t_hsv  in_word;
    hsv_pkg::t_rgb  out_word;
    hsv_pkg::t_work front_work;
    hsv_pkg::t_work queue_work;
    logic           front_valid, front_ready;
    logic           queue_valid, queue_ready;

    assign in_word = '{i_hsv.hue_deg, i_hsv.sat_level, i_hsv.val_level};

    hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_hsv.valid),
        .i_hsv   (in_word),
        .o_ready (i_hsv.ready),
        .o_valid (front_valid),
        .o_work  (front_work),
        .i_ready (front_ready)
    );

    hsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_work       (front_work),
        .o_push_ready (front_ready),
        .o_pop_valid  (queue_valid),
        .o_work       (queue_work),
        .i_pop_ready  (queue_ready)
    );

    hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_work  (queue_work),
        .o_ready (queue_ready),
        .o_valid (o_rgb.valid),
        .o_rgb   (out_word),
        .i_ready (o_rgb.ready)
    );

    assign o_rgb.red   = out_word.red;
    assign o_rgb.green = out_word.green;
    assign o_rgb.blue  = out_word.blue;

endmodule

/* sv/hsv_checker.sv */
// Port-level checker for the HSV to RGB converter, with its bind
`include "hsv_to_rgb_converter_defines.svh"

module hsv_checker #(
    parameter int unsigned QUEUE_DEPTH = hsv_pkg::QUEUE_DEPTH
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    localparam int unsigned CAPACITY =
        hsv_pkg::FRONT_STAGES + QUEUE_DEPTH + hsv_pkg::BACK_STAGES;
    localparam int unsigned CW = $clog2(CAPACITY + 2);

    logic [CW-1:0] r_outstanding, n_outstanding;
    logic          in_acc, out_acc;
    logic          out_stall, busy;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_acc   = i_out_valid && i_out_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign busy      = (r_outstanding != '0);

    // Count words taken in but not yet delivered
    always_comb begin
        n_outstanding = r_outstanding + CW'(in_acc) - CW'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    `HSV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid, "result word dropped")
    `HSV_ASSERT(a_no_phantom, i_clk, i_rst_n, busy || !i_out_valid, "result with none outstanding")
    `HSV_ASSERT(a_ready_empty, i_clk, i_rst_n, busy || i_in_ready, "empty block refuses input")
    `HSV_ASSERT(a_capacity, i_clk, i_rst_n, r_outstanding <= CW'(CAPACITY), "too many in flight")

endmodule

bind hsv_to_rgb_converter hsv_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_hsv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_hsv.valid),
    .i_in_ready  (i_hsv.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready)
);
